[hdl/assert_macros.svh]
// shared assertion macros for the block's checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion violated");

// sequence or condition must never occur outside reset
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
    else $error("forbidden condition seen");

`endif

[hdl/gcca_pkg.sv]
`default_nettype none
package gcca_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned VTX_W        = 10;
  localparam int unsigned CLS_W        = 11;
  localparam int unsigned TAG_W        = 10;
  localparam int unsigned CLS_DEPTH    = MAX_VERTICES + 1;
  localparam int unsigned TAG_SPAN     = 1023;

  localparam logic [TAG_W-1:0] SERIAL_LAST = TAG_W'(TAG_SPAN - 1);
  localparam logic [CLS_W-1:0] SIZE_MAX    = {CLS_W{1'b1}};
  localparam logic [CLS_W-1:0] MAX_CLS_RST = CLS_W'(MAX_VERTICES);
  localparam logic [CLS_W-1:0] SWEEP_LAST  = CLS_W'(CLS_DEPTH - 1);

  // request codes
  localparam logic [1:0] REQ_START    = 2'd0;
  localparam logic [1:0] REQ_NEIGHBOR = 2'd1;
  localparam logic [1:0] REQ_FINISH   = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] neighbor;
  } in_t;

  typedef struct packed {
    logic [VTX_W-1:0] out_vertex;
    logic [CLS_W-1:0] class_id;
    logic [VTX_W-1:0] position;
    logic             opened_new;
    logic [CLS_W-1:0] class_count;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NB_CLS,
    S_NB_TAB,
    S_NB_UPD,
    S_FIN_CALC,
    S_FIN_SIZE,
    S_TAGCLR
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clr_regs;
    logic sweep_all;
    logic sweep_tag;
    logic cls_rd;
    logic tab_rd;
    logic nb_upd;
    logic fin_rd;
    logic fin_out;
    logic next_vtx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       nb_ok;
    logic       q_zero;
    logic       v_ok;
    logic       wrap;
    logic       sweep_done;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

[hdl/gcca_ctrl.sv]
`default_nettype none
module gcca_ctrl import gcca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.req_type)
            REQ_START:    state_d = S_CLEAR;
            REQ_NEIGHBOR: state_d = S_NB_CLS;
            REQ_FINISH:   state_d = S_FIN_CALC;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_NB_CLS: begin
        state_d = sts_i.nb_ok ? S_NB_TAB : S_IDLE;
      end
      S_NB_TAB: begin
        state_d = sts_i.q_zero ? S_IDLE : S_NB_UPD;
      end
      S_NB_UPD: begin
        state_d = S_IDLE;
      end
      S_FIN_CALC: begin
        if (sts_i.v_ok) begin
          state_d = S_FIN_SIZE;
        end else begin
          state_d = sts_i.wrap ? S_TAGCLR : S_IDLE;
        end
      end
      S_FIN_SIZE: begin
        if (sts_i.out_free) state_d = sts_i.wrap ? S_TAGCLR : S_IDLE;
      end
      S_TAGCLR: begin
        if (sts_i.sweep_done) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.sweep_all = 1'b1;
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i && sts_i.req_type == REQ_START) cmd_o.clr_regs = 1'b1;
      end
      S_NB_CLS: begin
        cmd_o.cls_rd = sts_i.nb_ok;
      end
      S_NB_TAB: begin
        cmd_o.tab_rd = !sts_i.q_zero;
      end
      S_NB_UPD: begin
        cmd_o.nb_upd = 1'b1;
      end
      S_FIN_CALC: begin
        cmd_o.fin_rd   = sts_i.v_ok;
        cmd_o.next_vtx = !sts_i.v_ok;
      end
      S_FIN_SIZE: begin
        cmd_o.fin_out  = sts_i.out_free;
        cmd_o.next_vtx = sts_i.out_free;
      end
      S_TAGCLR: begin
        cmd_o.sweep_tag = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/gcca_dpath.sv]
`default_nettype none
module gcca_dpath import gcca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_t              in_data_i,
  input  logic             cfg_we_i,
  input  logic [CLS_W-1:0] cfg_wdata_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output out_t             out_data_o,
  input  cmd_t             cmd_i,
  output sts_t             sts_o
);

  // class tables
  logic [CLS_W-1:0] vc_mem   [MAX_VERTICES];
  logic [CLS_W-1:0] size_mem [CLS_DEPTH];
  logic [CLS_W-1:0] rem_mem  [CLS_DEPTH];
  logic [TAG_W-1:0] tag_mem  [CLS_DEPTH];

  logic [CLS_W-1:0] max_cls_q, max_cls_d;
  logic [CLS_W-1:0] cnt_q, cnt_d;
  logic [TAG_W-1:0] serial_q, serial_d;
  logic [CLS_W-1:0] best_q, best_d;
  logic [CLS_W-1:0] opened_q, opened_d;
  logic             out_valid_q, out_valid_d;

  in_t              in_q;
  logic [CLS_W-1:0] cls_rd_q;
  logic [CLS_W-1:0] q_q;
  logic [CLS_W-1:0] size_rd_q;
  logic [CLS_W-1:0] rem_rd_q;
  logic [TAG_W-1:0] tag_rd_q;
  logic [CLS_W-1:0] color_q;
  logic             opened_new_q;
  out_t             out_q;

  logic [TAG_W-1:0] cur_tag;
  logic [CLS_W-1:0] rem_eff, rem_new;
  logic             better;
  logic [CLS_W-1:0] limit;
  logic             can_open;
  logic [CLS_W-1:0] color_c;
  logic [CLS_W-1:0] size_inc;

  logic             vc_we;
  logic [VTX_W-1:0] vc_waddr;
  logic [CLS_W-1:0] vc_wdata;
  logic             size_we, size_re;
  logic [CLS_W-1:0] size_waddr, size_raddr, size_wdata;
  logic             tag_we;
  logic [CLS_W-1:0] tag_waddr;
  logic [TAG_W-1:0] tag_wdata;

  // neighbour update
  always_comb begin
    cur_tag = serial_q + TAG_W'(1);
    rem_eff = (tag_rd_q == cur_tag) ? rem_rd_q : size_rd_q;
    rem_new = (rem_eff != '0) ? rem_eff - CLS_W'(1) : rem_eff;
    better  = (rem_eff == CLS_W'(1)) && (best_q == '0 || q_q < best_q);
  end

  // class choice on finish
  always_comb begin
    limit    = (max_cls_q > CLS_W'(MAX_VERTICES)) ? CLS_W'(MAX_VERTICES) : max_cls_q;
    can_open = (best_q == '0) && (opened_q < limit);
    color_c  = can_open ? opened_q + CLS_W'(1) : best_q;
    size_inc = (size_rd_q == SIZE_MAX) ? size_rd_q : size_rd_q + CLS_W'(1);
  end

  always_comb begin
    max_cls_d   = cfg_we_i ? cfg_wdata_i : max_cls_q;
    cnt_d       = cnt_q;
    serial_d    = serial_q;
    best_d      = best_q;
    opened_d    = opened_q;
    out_valid_d = out_valid_q;
    if (cmd_i.clr_regs || cmd_i.next_vtx) begin
      cnt_d = '0;
    end else if (cmd_i.sweep_all || cmd_i.sweep_tag) begin
      cnt_d = cnt_q + CLS_W'(1);
    end
    if (cmd_i.clr_regs) begin
      serial_d = '0;
      best_d   = '0;
      opened_d = '0;
    end
    if (cmd_i.next_vtx) begin
      best_d   = '0;
      serial_d = (serial_q == SERIAL_LAST) ? '0 : serial_q + TAG_W'(1);
    end
    if (cmd_i.nb_upd && better) best_d = q_q;
    if (cmd_i.fin_rd && can_open) opened_d = opened_q + CLS_W'(1);
    if (cmd_i.fin_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cls_q   <= MAX_CLS_RST;
      cnt_q       <= '0;
      serial_q    <= '0;
      best_q      <= '0;
      opened_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      max_cls_q   <= max_cls_d;
      cnt_q       <= cnt_d;
      serial_q    <= serial_d;
      best_q      <= best_d;
      opened_q    <= opened_d;
      out_valid_q <= out_valid_d;
    end
  end

  // port selects
  always_comb begin
    vc_we      = (cmd_i.sweep_all && cnt_q < CLS_W'(MAX_VERTICES)) || cmd_i.fin_rd;
    vc_waddr   = cmd_i.fin_rd ? in_q.vertex : cnt_q[VTX_W-1:0];
    vc_wdata   = cmd_i.fin_rd ? color_c : '0;
    size_we    = cmd_i.sweep_all || cmd_i.fin_out;
    size_waddr = cmd_i.fin_out ? color_q : cnt_q;
    size_wdata = cmd_i.fin_out ? size_inc : '0;
    size_re    = cmd_i.tab_rd || cmd_i.fin_rd;
    size_raddr = cmd_i.fin_rd ? color_c : cls_rd_q;
    tag_we     = cmd_i.sweep_all || cmd_i.sweep_tag || cmd_i.nb_upd;
    tag_waddr  = cmd_i.nb_upd ? q_q : cnt_q;
    tag_wdata  = cmd_i.nb_upd ? cur_tag : '0;
  end

  always_ff @(posedge clk_i) begin
    if (vc_we) vc_mem[vc_waddr] <= vc_wdata;
    if (cmd_i.cls_rd) cls_rd_q <= vc_mem[in_q.neighbor];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) size_mem[size_waddr] <= size_wdata;
    if (size_re) size_rd_q <= size_mem[size_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (cmd_i.tab_rd) tag_rd_q <= tag_mem[cls_rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_upd) rem_mem[q_q] <= rem_new;
    if (cmd_i.tab_rd) rem_rd_q <= rem_mem[cls_rd_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_data_i;
    if (cmd_i.tab_rd) q_q <= cls_rd_q;
    if (cmd_i.fin_rd) begin
      color_q      <= color_c;
      opened_new_q <= can_open;
    end
    if (cmd_i.fin_out) begin
      out_q.out_vertex  <= in_q.vertex;
      out_q.class_id    <= color_q;
      out_q.position    <= size_rd_q[VTX_W-1:0];
      out_q.opened_new  <= opened_new_q;
      out_q.class_count <= opened_q;
    end
  end

  always_comb begin
    sts_o.req_type   = in_data_i.req_type;
    sts_o.nb_ok      = CLS_W'(in_q.neighbor) < CLS_W'(MAX_VERTICES);
    sts_o.q_zero     = (cls_rd_q == '0);
    sts_o.v_ok       = CLS_W'(in_q.vertex) < CLS_W'(MAX_VERTICES);
    sts_o.wrap       = (serial_q == SERIAL_LAST);
    sts_o.sweep_done = (cnt_q == SWEEP_LAST);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[hdl/greedy_clique_cover_assign_core.sv]
// channel    | handshake                 | payload
// -----------+---------------------------+----------------------------
// input      | in_valid_i / in_ready_o   | in_data_i   (in_t)
// output     | out_valid_o / out_ready_i | out_data_o  (out_t)
// config     | cfg_we_i (no wait)        | cfg_wdata_i (max_classes)
//
// a neighbour item steps through accept, class lookup, table read and update,
// set by the chain of synchronous table reads; a finish steps through accept,
// class choice and size update; a start item and reset both run a clearing
// sweep over the class tables, no input transfer is taken meanwhile
// every 1023rd finished vertex triggers a sweep of the tag table
// the result sits in an output register, so input transfers continue while it
// waits; a finish stalls only if the previous result is still not taken
`default_nettype none
module greedy_clique_cover_assign_core import gcca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [CLS_W-1:0] cfg_wdata_i
);

  // command and status between sequencer and table datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one item at a time, walks the lookup / update steps
  gcca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: vertex class, class size, scratch tables and the result register
  gcca_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

[hdl/gcca_chk.sv]
`default_nettype none
`include "assert_macros.svh"
module gcca_chk import gcca_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input in_t              in_data_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input out_t             out_data_o,
  input logic             cfg_we_i,
  input logic [CLS_W-1:0] cfg_wdata_i
);

  // a result waiting for its transfer holds still
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // a freshly opened class is the newest one and starts empty
  `ASSERT_AT(a_new_class, clk_i, rst_ni, out_valid_o && out_data_o.opened_new |-> out_data_o.class_id == out_data_o.class_count && out_data_o.position == '0)

  // the class given never lies beyond the classes opened
  `ASSERT_AT(a_class_range, clk_i, rst_ni, out_valid_o |-> out_data_o.class_id <= out_data_o.class_count && out_data_o.class_count <= CLS_W'(MAX_VERTICES))

  // a finish transfer keeps the input side busy in the next cycle
  `ASSERT_NEVER(a_fin_busy, clk_i, rst_ni, in_valid_i && in_ready_o && in_data_i.req_type == REQ_FINISH ##1 in_ready_o)

endmodule

bind greedy_clique_cover_assign_core gcca_chk u_gcca_chk (.*);
`default_nettype wire

[sim/tb_greedy_clique_cover_assign_core.sv]
`timescale 1ns / 1ps

module tb_greedy_clique_cover_assign_core;
  import gcca_pkg::*;

  // request code that the block must drop without a result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  // covers a clearing sweep of the class or tag tables plus margin
  localparam int SETTLE_CYCLES = 1100;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 520;
  localparam int LONG_VERTICES = 300;
  localparam int WATCHDOG_NS   = 12_000_000;

  // expected assignments, computed per accepted request
  class clique_board;
    bit [CLS_W-1:0] limit_reg;
    bit [CLS_W-1:0] cls_of   [MAX_VERTICES];
    bit [CLS_W-1:0] cls_size [CLS_DEPTH];
    bit [CLS_W-1:0] left_cnt [CLS_DEPTH];
    bit [TAG_W-1:0] seen_tag [CLS_DEPTH];
    bit [TAG_W-1:0] serial;
    bit [CLS_W-1:0] best;
    bit [CLS_W-1:0] opened;
    out_t           pending_assignments[$];
    int             errors;

    function new();
      limit_reg = MAX_CLS_RST;
      errors    = 0;
      clear_pass();
    endfunction

    function void clear_pass();
      foreach (cls_of[k]) cls_of[k] = '0;
      foreach (cls_size[k]) begin
        cls_size[k] = '0;
        left_cnt[k] = '0;
        seen_tag[k] = '0;
      end
      serial = '0;
      best   = '0;
      opened = '0;
    endfunction

    function int pending();
      return pending_assignments.size();
    endfunction

    function void predict_assignment(in_t it);
      bit [CLS_W-1:0] q;
      bit [TAG_W-1:0] tag;
      bit [CLS_W-1:0] lim;
      bit [CLS_W-1:0] cls;
      bit [CLS_W-1:0] pos;
      bit             fresh;
      out_t           r;
      case (it.req_type)
        REQ_START: clear_pass();
        REQ_NEIGHBOR: begin
          q   = cls_of[it.neighbor];
          tag = serial + 1'b1;
          if (q != 0) begin
            if (seen_tag[q] != tag) begin
              seen_tag[q] = tag;
              left_cnt[q] = cls_size[q];
            end
            if (left_cnt[q] != 0) begin
              left_cnt[q]--;
              if (left_cnt[q] == 0 && (best == 0 || q < best)) best = q;
            end
          end
        end
        REQ_FINISH: begin
          lim   = (limit_reg > MAX_VERTICES) ? CLS_W'(MAX_VERTICES) : limit_reg;
          cls   = best;
          fresh = 1'b0;
          if (cls == 0 && opened < lim) begin
            opened++;
            cls   = opened;
            fresh = 1'b1;
          end
          cls_of[it.vertex] = cls;
          pos = cls_size[cls];
          if (cls_size[cls] != SIZE_MAX) cls_size[cls]++;
          r.out_vertex  = it.vertex;
          r.class_id    = cls;
          r.position    = pos[VTX_W-1:0];
          r.opened_new  = fresh;
          r.class_count = opened;
          pending_assignments.push_back(r);
          best = '0;
          if (serial == SERIAL_LAST) begin
            serial = '0;
            foreach (seen_tag[k]) seen_tag[k] = '0;
          end else begin
            serial++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_assignment(out_t got);
      out_t want;
      if (pending_assignments.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result vtx %0d cls %0d pos %0d new %0d cnt %0d",
                   $time, got.out_vertex, got.class_id, got.position,
                   got.opened_new, got.class_count);
        return;
      end
      want = pending_assignments.pop_front();
      if (got.out_vertex !== want.out_vertex || got.class_id !== want.class_id ||
          got.position !== want.position || got.opened_new !== want.opened_new ||
          got.class_count !== want.class_count) begin
        errors++;
        if (errors <= 10) begin
          $write("%0t: mismatch exp vtx %0d cls %0d pos %0d new %0d cnt %0d",
                 $time, want.out_vertex, want.class_id, want.position,
                 want.opened_new, want.class_count);
          $display(" / act vtx %0d cls %0d pos %0d new %0d cnt %0d",
                   got.out_vertex, got.class_id, got.position,
                   got.opened_new, got.class_count);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [CLS_W-1:0] cfg_wdata = '0;

  clique_board board;
  int          fed_items = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  bit          hold_req = 1'b0;

  greedy_clique_cover_assign_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [VTX_W-1:0] any_vtx();
    return VTX_W'($urandom);
  endfunction

  // one request transfer, called and returning at a falling edge
  task automatic send_req(input logic [1:0] req, input logic [VTX_W-1:0] vtx,
                          input logic [VTX_W-1:0] nb);
    in_t it;
    it.req_type = req;
    it.vertex   = vtx;
    it.neighbor = nb;
    if (req != REQ_UNUSED) fed_items++;
    // random gaps before offering, valid stays low meanwhile
    while (in_idle_on && $urandom_range(99) < 26) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.predict_assignment(it);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // limit register only changes once the block has drained and settled
  task automatic write_limit(input logic [CLS_W-1:0] value);
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we          = 1'b1;
    cfg_wdata       = value;
    board.limit_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // small random graph, every vertex sent with its true neighbour list plus noise
  task automatic run_graph_pass(input bit open_pass);
    int               n;
    int               dens;
    int               roll;
    bit               adj [14][14];
    logic [VTX_W-1:0] ids [14];
    n    = $urandom_range(2, 14);
    dens = $urandom_range(20, 95);
    for (int i = 0; i < n; i++) begin
      ids[i] = any_vtx();
      // sometimes the same vertex comes back for a second finish
      if (i > 0 && $urandom_range(99) < 8) ids[i] = ids[$urandom_range(0, i - 1)];
      adj[i][i] = 1'b0;
      for (int j = 0; j < i; j++) begin
        adj[i][j] = ($urandom_range(99) < dens);
        adj[j][i] = adj[i][j];
      end
    end
    if (open_pass) send_req(REQ_START, any_vtx(), any_vtx());
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (adj[i][j]) begin
          send_req(REQ_NEIGHBOR, any_vtx(), ids[j]);
          // repeated neighbour counts once more
          if ($urandom_range(99) < 5) send_req(REQ_NEIGHBOR, any_vtx(), ids[j]);
        end
      end
      // noise: dropped request code or a stray neighbour
      roll = $urandom_range(99);
      if (roll < 4) send_req(REQ_UNUSED, any_vtx(), any_vtx());
      else if (roll < 10) send_req(REQ_NEIGHBOR, any_vtx(), any_vtx());
      send_req(REQ_FINISH, ids[i], any_vtx());
    end
  endtask

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !(out_idle_on && $urandom_range(99) < 26);
      end
    end
  end

  // every accepted result transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_assignment(out_data);
  end

  initial begin
    #WATCHDOG_NS;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int               pass_no;
    bit               quiet;
    logic [CLS_W-1:0] lim_pick;
    board = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, ignored code, covering by duplicates,
    // repeated finish, pass restart
    send_req(REQ_START, '1, '1);
    send_req(REQ_UNUSED, '1, '1);
    send_req(REQ_FINISH, '0, '1);            // opens class 1
    send_req(REQ_NEIGHBOR, '1, '0);
    send_req(REQ_FINISH, '1, '0);            // joins class 1
    send_req(REQ_NEIGHBOR, '0, 10'd5);       // not yet assigned, no effect
    send_req(REQ_FINISH, 10'd5, '0);         // opens class 2
    send_req(REQ_NEIGHBOR, '0, '0);
    send_req(REQ_NEIGHBOR, '0, '0);          // duplicate covers class 1
    send_req(REQ_FINISH, 10'd7, '0);
    send_req(REQ_NEIGHBOR, '0, 10'd5);
    send_req(REQ_NEIGHBOR, '0, 10'd5);
    send_req(REQ_NEIGHBOR, '0, 10'd5);       // remaining count stays at zero
    send_req(REQ_FINISH, 10'd9, '0);
    send_req(REQ_FINISH, '0, '0);            // second finish of vertex 0
    send_req(REQ_UNUSED, '0, '0);
    send_req(REQ_START, '0, '0);
    send_req(REQ_FINISH, 10'd512, '0);
    // zero limit: uncovered vertices fall into class 0
    write_limit('0);
    send_req(REQ_FINISH, 10'd3, '0);
    send_req(REQ_FINISH, 10'd4, '0);
    write_limit(CLS_W'(1));
    send_req(REQ_START, '0, '0);
    send_req(REQ_FINISH, 10'd10, '0);
    send_req(REQ_FINISH, 10'd11, '0);        // limit reached
    // over-range limit is capped at the vertex count
    write_limit('1);
    send_req(REQ_NEIGHBOR, '0, 10'd10);
    send_req(REQ_FINISH, 10'd12, '0);
    send_req(REQ_FINISH, 10'd13, '0);

    // random graph passes with varied limits
    fed_items = 0;
    pass_no   = 0;
    while (fed_items < RANDOM_ITEMS) begin
      if (pass_no == 0 || $urandom_range(99) < 30) begin
        case ($urandom_range(5))
          0: lim_pick = '0;
          1: lim_pick = CLS_W'($urandom_range(1, 3));
          2: lim_pick = CLS_W'($urandom_range(1, 16));
          3: lim_pick = MAX_CLS_RST;
          4: lim_pick = '1;
          default: lim_pick = CLS_W'($urandom);
        endcase
        write_limit(lim_pick);
      end
      // a stretch of passes with no gaps on either side
      quiet       = (pass_no >= 3 && pass_no < 7);
      in_idle_on  = !quiet;
      out_idle_on = !quiet;
      run_graph_pass(pass_no == 0 || $urandom_range(99) < 85);
      pass_no++;
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    // one long pass: two classes, most vertices fall into class 0, and the
    // receiver holds off while finishes keep coming
    write_limit(CLS_W'(2));
    send_req(REQ_START, any_vtx(), any_vtx());
    for (int k = 0; k < LONG_VERTICES; k++) begin
      if (k == 100) hold_req = 1'b1;
      if (k >= 2 && $urandom_range(99) < 12) begin
        repeat ($urandom_range(1, 3))
          send_req(REQ_NEIGHBOR, any_vtx(),
                   ($urandom_range(99) < 50) ? VTX_W'($urandom_range(0, 1)) : any_vtx());
      end
      send_req(REQ_FINISH,
               (k < 2) ? VTX_W'(k) : VTX_W'($urandom_range(2, MAX_VERTICES - 1)),
               any_vtx());
    end

    // drain, then allow stray results to show up
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
